// File: rtl/mdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared types and constants for the datagram deframer: sections of a
// datagram, header layout, size limits and the token that runs from the
// parsing front end through the queue to the result stage.
// ----------------------------------------------------------------------------
package mdd_pkg;

	localparam int MAX_DATAGRAM = 2048;
	localparam int POS_W        = 12;
	localparam int POS_MAX      = 4095;
	localparam int OFFSET_W     = 11;
	localparam int SESSION_LAST = 9;
	localparam int SEQ_LAST     = 17;
	localparam int COUNT_LAST   = 19;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		SEC_SESSION  = 3'd0,
		SEC_SEQUENCE = 3'd1,
		SEC_COUNT    = 3'd2,
		SEC_LENGTH   = 3'd3,
		SEC_PAYLOAD  = 3'd4,
		SEC_EXCESS   = 3'd5
	} section_t;

	typedef struct packed {
		section_t              cls;
		logic [7:0]            value;
		logic [OFFSET_W-1:0]   offset;
		logic [15:0]           count;
		logic [15:0]           index;
		logic [15:0]           length;
		logic                  ended;
		logic                  done;
		logic                  truncated;
		logic                  overlong;
		logic                  last;
	} token_t;

endpackage
`default_nettype wire

// File: rtl/mdd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_front
// Parsing front end. Tracks the section of the datagram, the message count,
// the message lengths and the remaining payload, and classifies each byte
// into a token for the queue.
// ----------------------------------------------------------------------------
module mdd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	input  wire logic            q_full,
	output logic                 in_stall,
	output logic                 push,
	output mdd_pkg::token_t      push_token
);

	mdd_pkg::section_t              sec_q, sec_d;
	logic [mdd_pkg::POS_W-1:0]      pos_q;
	logic [15:0]                    count_q, count_d;
	logic [15:0]                    fin_q, fin_d;
	logic [15:0]                    len_q, len_d;
	logic [15:0]                    left_q, left_d;
	logic                           phase_q, phase_d;
	logic                           ended;
	logic                           done;
	logic                           finish;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		sec_d   = sec_q;
		count_d = count_q;
		fin_d   = fin_q;
		len_d   = len_q;
		left_d  = left_q;
		phase_d = phase_q;
		ended   = 1'b0;
		finish  = 1'b0;
		unique case (sec_q)
			mdd_pkg::SEC_SESSION: begin
				if (pos_q >= mdd_pkg::POS_W'(mdd_pkg::SESSION_LAST)) begin
					sec_d = mdd_pkg::SEC_SEQUENCE;
				end
			end
			mdd_pkg::SEC_SEQUENCE: begin
				if (pos_q >= mdd_pkg::POS_W'(mdd_pkg::SEQ_LAST)) begin
					sec_d = mdd_pkg::SEC_COUNT;
				end
			end
			mdd_pkg::SEC_COUNT: begin
				count_d = {count_q[7:0], data_byte};
				if (pos_q >= mdd_pkg::POS_W'(mdd_pkg::COUNT_LAST)) begin
					if (count_d == 16'd0) begin
						sec_d = mdd_pkg::SEC_EXCESS;
					end else begin
						sec_d   = mdd_pkg::SEC_LENGTH;
						phase_d = 1'b0;
					end
				end
			end
			mdd_pkg::SEC_LENGTH: begin
				if (!phase_q) begin
					len_d   = {data_byte, 8'h00};
					phase_d = 1'b1;
				end else begin
					len_d   = {len_q[15:8], data_byte};
					left_d  = len_d;
					phase_d = 1'b0;
					if (len_d == 16'd0) begin
						ended  = 1'b1;
						finish = 1'b1;
					end else begin
						sec_d = mdd_pkg::SEC_PAYLOAD;
					end
				end
			end
			mdd_pkg::SEC_PAYLOAD: begin
				left_d = left_q - 16'd1;
				if (left_d == 16'd0) begin
					ended  = 1'b1;
					finish = 1'b1;
				end
			end
			default: begin
				sec_d = mdd_pkg::SEC_EXCESS;
			end
		endcase
		if (finish) begin
			fin_d = fin_q + 16'd1;
			if (fin_d == count_q) begin
				sec_d = mdd_pkg::SEC_EXCESS;
			end else begin
				sec_d   = mdd_pkg::SEC_LENGTH;
				phase_d = 1'b0;
			end
		end
	end

	assign done = (sec_d == mdd_pkg::SEC_EXCESS);

	always_comb begin
		push_token.cls       = sec_q;
		push_token.value     = data_byte;
		push_token.offset    = pos_q[mdd_pkg::OFFSET_W-1:0];
		push_token.count     = count_d;
		push_token.index     = fin_q;
		push_token.length    = len_d;
		push_token.ended     = ended;
		push_token.done      = done;
		push_token.truncated = last_byte && !done;
		push_token.overlong  = {1'b0, pos_q} >= (mdd_pkg::POS_W + 1)'(mdd_pkg::MAX_DATAGRAM);
		push_token.last      = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= mdd_pkg::SEC_SESSION;
			pos_q   <= '0;
			count_q <= '0;
			fin_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
			phase_q <= 1'b0;
		end else if (push) begin
			if (last_byte) begin
				sec_q   <= mdd_pkg::SEC_SESSION;
				pos_q   <= '0;
				count_q <= '0;
				fin_q   <= '0;
				len_q   <= '0;
				left_q  <= '0;
				phase_q <= 1'b0;
			end else begin
				sec_q   <= sec_d;
				count_q <= count_d;
				fin_q   <= fin_d;
				len_q   <= len_d;
				left_q  <= left_d;
				phase_q <= phase_d;
				if (pos_q < mdd_pkg::POS_W'(mdd_pkg::POS_MAX)) begin
					pos_q <= pos_q + mdd_pkg::POS_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/mdd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_queue
// Short first-in first-out queue of byte tokens between the parsing front
// end and the result stage.
// ----------------------------------------------------------------------------
module mdd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mdd_pkg::token_t push_token,
	input  wire logic            pop,
	output logic                 full,
	output logic                 q_valid,
	output mdd_pkg::token_t      pop_token
);

	mdd_pkg::token_t             mem_q [mdd_pkg::QUEUE_DEPTH];
	logic [mdd_pkg::QPTR_W-1:0]  wr_q;
	logic [mdd_pkg::QPTR_W-1:0]  rd_q;
	logic [mdd_pkg::QCNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == mdd_pkg::QCNT_W'(mdd_pkg::QUEUE_DEPTH));
	assign q_valid   = (cnt_q != '0);
	assign pop_token = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + mdd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + mdd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + mdd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - mdd_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/mdd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_back
// Result stage. Assembles the 64-bit sequence number from the sequence bytes
// and holds each finished result in an output register until it is taken.
// ----------------------------------------------------------------------------
module mdd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire mdd_pkg::token_t             pop_token,
	output logic                             pop,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic [2:0]                       byte_class,
	output logic [7:0]                       byte_value,
	output logic [mdd_pkg::OFFSET_W-1:0]     byte_offset,
	output logic [63:0]                      seq_number,
	output logic [15:0]                      msg_count,
	output logic [15:0]                      message_index,
	output logic [15:0]                      message_length,
	output logic                             message_end,
	output logic                             packet_done,
	output logic                             truncated,
	output logic                             overlong
);

	logic                   out_valid_q;
	logic [63:0]            seq_q;
	logic [63:0]            seq_d;
	mdd_pkg::token_t        tok_q;
	logic [63:0]            seq_out_q;

	assign pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		seq_d = seq_q;
		if (pop_token.cls == mdd_pkg::SEC_SEQUENCE) begin
			seq_d = {seq_q[55:0], pop_token.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seq_q       <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				seq_q       <= pop_token.last ? 64'd0 : seq_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q     <= pop_token;
			seq_out_q <= seq_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign byte_class      = tok_q.cls;
	assign byte_value      = tok_q.value;
	assign byte_offset     = tok_q.offset;
	assign seq_number      = seq_out_q;
	assign msg_count       = tok_q.count;
	assign message_index   = tok_q.index;
	assign message_length  = tok_q.length;
	assign message_end     = tok_q.ended;
	assign packet_done     = tok_q.done;
	assign truncated       = tok_q.truncated;
	assign overlong        = tok_q.overlong;

endmodule
`default_nettype wire

// File: rtl/moldudp64_datagram_deframer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moldudp64_datagram_deframer_core
// Splits a MoldUDP64 datagram, one byte per beat, into session, sequence,
// count, message length, payload and excess bytes, with one result beat per byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_stall is low and gives
// one result beat per byte, in order. A result passes through the queue and
// the output register after its byte is accepted. The rate is set by the
// parsing front end, which updates the section, count, length and payload
// counters for each accepted byte. A four-entry queue and an output register
// separate it from the result side, so input flows until five results wait.
module moldudp64_datagram_deframer_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        last_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       byte_class,
	output logic [7:0]                       byte_value,
	output logic [mdd_pkg::OFFSET_W-1:0]     byte_offset,
	output logic [63:0]                      seq_number,
	output logic [15:0]                      msg_count,
	output logic [15:0]                      message_index,
	output logic [15:0]                      message_length,
	output logic                             message_end,
	output logic                             packet_done,
	output logic                             truncated,
	output logic                             overlong
);

	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_valid;
	mdd_pkg::token_t    push_token;
	mdd_pkg::token_t    pop_token;

	mdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_token (push_token)
	);

	mdd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.pop        (pop),
		.full       (q_full),
		.q_valid    (q_valid),
		.pop_token  (pop_token)
	);

	mdd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.pop_token       (pop_token),
		.pop             (pop),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.byte_class      (byte_class),
		.byte_value      (byte_value),
		.byte_offset     (byte_offset),
		.seq_number      (seq_number),
		.msg_count       (msg_count),
		.message_index   (message_index),
		.message_length  (message_length),
		.message_end     (message_end),
		.packet_done     (packet_done),
		.truncated       (truncated),
		.overlong        (overlong)
	);

endmodule
`default_nettype wire

// File: rtl/mdd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_checker
// Port-level checks for the datagram deframer, attached to the top level.
// ----------------------------------------------------------------------------
module mdd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [2:0]                  byte_class,
	input wire logic [7:0]                  byte_value,
	input wire logic [mdd_pkg::OFFSET_W-1:0] byte_offset,
	input wire logic                        message_end,
	input wire logic                        packet_done,
	input wire logic                        truncated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_value)
			&& $stable(byte_offset) && $stable(byte_class))
		else $error("result beat changed while stalled");

	a_end_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |->
			(byte_class == mdd_pkg::SEC_LENGTH) || (byte_class == mdd_pkg::SEC_PAYLOAD))
		else $error("message end on a byte that is not length or payload");

	a_excess_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_class == mdd_pkg::SEC_EXCESS) |-> packet_done)
		else $error("excess byte without packet done");

	a_trunc_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> !packet_done)
		else $error("truncation flagged on a finished packet");

endmodule

bind moldudp64_datagram_deframer_core mdd_checker u_mdd_checker (.*);
`default_nettype wire
